// ===== rtl/core/cross_binary_morphology_macros.svh =====
// Assertion macros shared by the checker of the cross morphology block.
// Each macro expects a signal named clk, and CBM_ASSERT_IMP also rst_n, in the scope where it is used.
`ifndef CROSS_BINARY_MORPHOLOGY_MACROS_SVH
`define CROSS_BINARY_MORPHOLOGY_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbm assertion failed");

// Next-cycle implication, also checked across reset.
`define CBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cbm assertion failed");

`endif

// ===== rtl/core/cbm_pkg.sv =====
// Shared types and constants of the cross morphology block.
// Used by cbm_stage, cross_binary_morphology and cbm_checker; no dependencies.
`timescale 1ns / 1ps
package cbm_pkg;
  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  localparam logic [1:0] MODE_ERODE = 2'd0;
  localparam logic [1:0] MODE_DILATE = 2'd1;
  localparam logic [1:0] MODE_OPEN = 2'd2;
  localparam logic [1:0] MODE_CLOSE = 2'd3;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [PIX_W-1:0] PIX_SET = 8'd255;
  localparam logic [PIX_W-1:0] PIX_CLR = 8'd0;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             end_of_line;
    logic             end_of_frame;
  } out_t;

  // Which cross neighbors of the current center lie inside the image.
  typedef struct packed {
    logic left;
    logic right;
    logic up;
    logic down;
  } nbr_t;
endpackage

// ===== rtl/core/cbm_stage.sv =====
// One morphology stage: a two-line store in one memory plus the cross test.
// Depends on cbm_pkg.
`timescale 1ns / 1ps
module cbm_stage #(
  parameter int MAX_WIDTH = cbm_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              adv,
  input  logic [$clog2(MAX_WIDTH)-1:0]      wr_col,
  input  logic [$clog2(MAX_WIDTH)-1:0]      rd_col,
  input  logic [$clog2(MAX_WIDTH)-1:0]      rd2_col,
  input  logic [cbm_pkg::PIX_W-1:0]         pix_in,
  input  cbm_pkg::nbr_t                     nbr,
  input  logic                              dilate,
  output logic [cbm_pkg::PIX_W-1:0]         pix_out
);
  import cbm_pkg::*;

  // Each word holds the pixel one row back (low) and two rows back (high).
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] word_r;
  logic [PIX_W-1:0]   right_r;
  logic [PIX_W-1:0]   left_r;
  logic [2*PIX_W-1:0] wr_word;
  logic               c_set, l_set, r_set, u_set, d_set, any_set, all_set;

  assign wr_word = {word_r[PIX_W-1:0], pix_in};

  // word_r always mirrors the entry at the current column; a read that hits
  // the entry being written takes the new word instead.
  always_ff @(posedge clk) begin
    if (adv) begin
      line_mem[wr_col] <= wr_word;
      left_r <= word_r[PIX_W-1:0];
    end
    if (adv && rd_col == wr_col) begin
      word_r <= wr_word;
    end else begin
      word_r <= line_mem[rd_col];
    end
    if (adv && rd2_col == wr_col) begin
      right_r <= pix_in;
    end else begin
      right_r <= line_mem[rd2_col][PIX_W-1:0];
    end
  end

  always_comb begin
    c_set = word_r[PIX_W-1:0] != PIX_CLR;
    l_set = left_r != PIX_CLR;
    r_set = right_r != PIX_CLR;
    u_set = word_r[2*PIX_W-1:PIX_W] != PIX_CLR;
    d_set = pix_in != PIX_CLR;
    any_set = c_set | (nbr.left & l_set) | (nbr.right & r_set) |
              (nbr.up & u_set) | (nbr.down & d_set);
    all_set = c_set & (!nbr.left | l_set) & (!nbr.right | r_set) &
              (!nbr.up | u_set) & (!nbr.down | d_set);
    if (any_set && !all_set) begin
      pix_out = dilate ? PIX_SET : PIX_CLR;
    end else begin
      pix_out = word_r[PIX_W-1:0];
    end
  end
endmodule

// ===== rtl/core/cross_binary_morphology.sv =====
// Binary morphology with a 3x3 cross element over a raster pixel stream.
//
// Input channel in_*: one request per pixel (cmd pixel) or a flush request
// (cmd flush). Output channel out_*: processed pixels in raster order with
// end of line and end of frame marks. Config port cfg_*: width, height and
// mode, sampled when the first pixel of a frame is taken.
// Erosion and dilation use one stage, so output lags input by one row;
// opening and closing cascade two stages and lag by two rows. After the
// last input pixel, one or two rows of flush requests drain the frame.
// Throughput is one request per clock unless a result stalls; each result
// is registered as its request is taken. Each stage keeps two lines in one
// memory read at two columns each cycle, so the line stores set the rate.
// A flush before the frame is complete is dropped with no result.
// Reset clears the frame position and output valid flag; the line memories
// are not cleared and need no clearing pass. When the receiver stalls a
// waiting result, in_stall rises and the result holds until taken.
`timescale 1ns / 1ps
module cross_binary_morphology #(
  parameter int MAX_WIDTH = cbm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cbm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cbm_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cbm_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [cbm_pkg::CFG_W-1:0]  cfg_wdata
);
  import cbm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);

  logic [CFG_W-1:0] width_cfg_r, height_cfg_r;
  logic [1:0]       mode_cfg_r;
  logic [WW-1:0]    cur_w_r, w_clamp, w_use;
  logic [HW-1:0]    cur_h_r, h_clamp, h_use;
  logic [1:0]       cur_mode_r, mode_use;
  logic             active_r, active_nxt;
  logic [CW-1:0]    col_r, col_nxt, rd2_col;
  logic [RW-1:0]    row_r, row_nxt, stages, h_row;
  logic             acc, adv, two, last_col, emit, eof, in_frame;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r;
  nbr_t             nbr1, nbr2;
  logic [PIX_W-1:0] v1, v2;

  always_comb begin
    if (width_cfg_r == '0) begin
      w_clamp = WW'(1);
    end else if (32'(width_cfg_r) > 32'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(width_cfg_r);
    end
    if (height_cfg_r == '0) begin
      h_clamp = HW'(1);
    end else if (32'(height_cfg_r) > 32'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(height_cfg_r);
    end
  end

  // Outside a frame the next pixel starts one with the written registers.
  assign w_use = active_r ? cur_w_r : w_clamp;
  assign h_use = active_r ? cur_h_r : h_clamp;
  assign mode_use = active_r ? cur_mode_r : mode_cfg_r;
  assign two = (mode_use == MODE_OPEN) || (mode_use == MODE_CLOSE);
  assign stages = two ? RW'(2) : RW'(1);
  assign h_row = RW'(h_use);

  assign in_stall = out_valid_r && out_stall;
  assign acc = in_valid && !in_stall;
  assign in_frame = row_r < h_row;
  assign adv = acc && (in_data.cmd == CMD_PIXEL || (active_r && !in_frame));
  assign last_col = WW'(col_r) == w_use - WW'(1);
  assign emit = row_r >= stages && row_r < h_row + stages;
  assign eof = emit && last_col && row_r == h_row + stages - RW'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    active_nxt = active_r;
    if (adv) begin
      active_nxt = !eof;
      if (eof) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
    if (WW'(col_nxt) + WW'(1) == w_use) begin
      rd2_col = '0;
    end else begin
      rd2_col = col_nxt + CW'(1);
    end
  end

  always_comb begin
    nbr1.left = col_r != '0;
    nbr1.right = WW'(col_r) + WW'(1) < w_use;
    nbr1.up = row_r > RW'(1);
    nbr1.down = row_r < h_row;
    nbr2.left = nbr1.left;
    nbr2.right = nbr1.right;
    nbr2.up = row_r > RW'(2);
    nbr2.down = row_r < h_row + RW'(1);
  end

  cbm_stage #(.MAX_WIDTH(MAX_WIDTH)) u_stage1 (
    .clk     (clk),
    .adv     (adv),
    .wr_col  (col_r),
    .rd_col  (col_nxt),
    .rd2_col (rd2_col),
    .pix_in  (in_data.pixel),
    .nbr     (nbr1),
    .dilate  (mode_use == MODE_DILATE || mode_use == MODE_CLOSE),
    .pix_out (v1)
  );

  cbm_stage #(.MAX_WIDTH(MAX_WIDTH)) u_stage2 (
    .clk     (clk),
    .adv     (adv),
    .wr_col  (col_r),
    .rd_col  (col_nxt),
    .rd2_col (rd2_col),
    .pix_in  (v1),
    .nbr     (nbr2),
    .dilate  (mode_use == MODE_OPEN),
    .pix_out (v2)
  );

  assign out_valid_nxt = (adv && emit) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r <= WIDTH_RESET;
      height_cfg_r <= HEIGHT_RESET;
      mode_cfg_r <= MODE_ERODE;
      cur_w_r <= WW'(640);
      cur_h_r <= HW'(480);
      cur_mode_r <= MODE_ERODE;
      active_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  width_cfg_r <= cfg_wdata;
          REG_HEIGHT: height_cfg_r <= cfg_wdata;
          REG_MODE:   mode_cfg_r <= cfg_wdata[1:0];
          default:    ;
        endcase
      end
      if (adv && !active_r) begin
        cur_w_r <= w_clamp;
        cur_h_r <= h_clamp;
        cur_mode_r <= mode_cfg_r;
      end
      active_r <= active_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_data_r.out_pixel <= two ? v2 : v1;
      out_data_r.end_of_line <= last_col;
      out_data_r.end_of_frame <= eof;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
endmodule

// ===== rtl/core/cbm_checker.sv =====
// Port-level checks of the cross morphology block, bound to its top level.
// Depends on cbm_pkg and cross_binary_morphology_macros.svh.
`timescale 1ns / 1ps
`include "cross_binary_morphology_macros.svh"
module cbm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input cbm_pkg::out_t out_data
);
  import cbm_pkg::*;

  // The block only pushes back while a finished result waits.
  `CBM_ASSERT_IMP(a_stall_needs_result, in_stall, out_valid && out_stall)
  // A frame can only end on the last pixel of a row.
  `CBM_ASSERT_IMP(a_eof_on_eol, out_valid && out_data.end_of_frame, out_data.end_of_line)
  `CBM_ASSERT_NXT(a_reset_empty, !rst_n, !out_valid)
  `CBM_ASSERT_IMP(a_hold, rst_n && $past(rst_n) && $past(out_valid && out_stall),
                  out_valid && out_data == $past(out_data))
endmodule

bind cross_binary_morphology cbm_checker u_cbm_checker (.*);
